[src/lfpd_pkg.sv]
// lfpd_pkg: shared widths, register indexes, configuration struct and the
// sensor pattern table of the line-following PID drive.
// No dependencies.
`default_nettype none

package lfpd_pkg;

   localparam int SENSOR_COUNT = 12;
   localparam int SAMPLE_W     = 12;
   localparam int SPEED_W      = 9;
   localparam int ERR_W        = 9;
   localparam int DELTA_W      = ERR_W + 1;
   localparam int GAIN_W       = 16;
   localparam int GAIN_FRAC    = 10;
   localparam int SUM_BITS_DEF = 24;
   // accumulator headroom over the error sum: gain bits, signed gain bit plus carries
   localparam int ACC_EXTRA    = GAIN_W + 3;
   // correction is clipped to this width before it meets the base speeds
   localparam int CORR_W       = 11;
   localparam int CORR_LIMIT   = 1023;
   localparam int SPEED_LIMIT  = 255;
   localparam int DRIVE_W      = 12;

   localparam int REQ_DATA_W   = SENSOR_COUNT * SAMPLE_W;
   localparam int RSP_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = 3;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd3700;

   localparam logic signed [ERR_W-1:0] ERR_LOST_POS = 9'sd100;
   localparam logic signed [ERR_W-1:0] ERR_LOST_NEG = -9'sd100;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE_LEFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_RIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REAR_BANK  = 3'd6;

   typedef struct packed {
      logic signed [SPEED_W-1:0] base_left;
      logic signed [SPEED_W-1:0] base_right;
      logic [GAIN_W-1:0]         gain_p;
      logic [GAIN_W-1:0]         gain_i;
      logic [GAIN_W-1:0]         gain_d;
      logic [SAMPLE_W-1:0]       line_threshold;
      logic                      rear_bank;
   } cfg_type;

   // sensor pattern to position error; unlisted patterns give zero
   function automatic logic signed [ERR_W-1:0] lookup_error(
      input logic [SENSOR_COUNT-1:0] pattern);
      logic signed [ERR_W-1:0] err;
      case (pattern)
         12'hFC0: err = -9'sd50;
         12'hF80: err = -9'sd90;
         12'hF00: err = -9'sd100;
         12'h800: err = -9'sd76;
         12'hC00: err = -9'sd60;
         12'h400: err = -9'sd46;
         12'h600: err = -9'sd34;
         12'h200: err = -9'sd24;
         12'h300: err = -9'sd16;
         12'h100: err = -9'sd10;
         12'h180: err = -9'sd6;
         12'h080: err = -9'sd4;
         12'h0C0: err = -9'sd2;
         12'h070: err = 9'sd1;
         12'h030: err = 9'sd2;
         12'h010: err = 9'sd4;
         12'h018: err = 9'sd6;
         12'h008: err = 9'sd10;
         12'h00C: err = 9'sd16;
         12'h004: err = 9'sd24;
         12'h006: err = 9'sd34;
         12'h002: err = 9'sd46;
         12'h003: err = 9'sd60;
         12'h001: err = 9'sd76;
         12'h00F: err = 9'sd100;
         12'h01F: err = 9'sd90;
         12'h000: err = 9'sd100;   // line lost
         12'hFFF: err = 9'sd200;   // full cross
         12'h07F: err = 9'sd50;
         default: err = 9'sd0;
      endcase
      return err;
   endfunction

endpackage

`default_nettype wire

[src/lfpd_error.sv]
// lfpd_error: request register for one sensor scan, thresholding and
// pattern lookup giving the signed line error, negated for the rear bank. Uses lfpd_pkg.
`default_nettype none

module lfpd_error
   import lfpd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [REQ_DATA_W-1:0]      in_samples,
   input  wire logic [SAMPLE_W-1:0]        line_threshold,
   input  wire logic                       rear_bank,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic signed [ERR_W-1:0]         out_error
);

   logic                    valid_ff, valid_in;
   logic [REQ_DATA_W-1:0]   samples_ff, samples_in;
   logic [SENSOR_COUNT-1:0] pattern;
   logic signed [ERR_W-1:0] raw_error;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in   = valid_ff;
      samples_in = samples_ff;
      if (in_ready) begin
         valid_in   = in_valid;
         samples_in = in_samples;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      samples_ff <= samples_in;
   end

   // sample 0 is the leftmost sensor and lands in the top pattern bit
   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         pattern[SENSOR_COUNT-1-i] = samples_ff[i*SAMPLE_W +: SAMPLE_W] >= line_threshold;
      end
      raw_error = lookup_error(pattern);
      out_error = rear_bank ? -raw_error : raw_error;
   end

   assign out_valid = valid_ff;

endmodule

`default_nettype wire

[src/lfpd_pid.sv]
// lfpd_pid: PID state (previous error, saturating error sum), the three gain
// products and their sum in Q.10. Three register stages. Uses lfpd_pkg.
`default_nettype none

module lfpd_pid
   import lfpd_pkg::*;
#(
   parameter int SUM_BITS = SUM_BITS_DEF
)(
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic signed [ERR_W-1:0]          in_error,
   input  wire logic [GAIN_W-1:0]                gain_p,
   input  wire logic [GAIN_W-1:0]                gain_i,
   input  wire logic [GAIN_W-1:0]                gain_d,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic signed [SUM_BITS+ACC_EXTRA-1:0]  out_acc,
   output logic signed [ERR_W-1:0]               out_error
);

   localparam int ACC_W  = SUM_BITS + ACC_EXTRA;
   localparam int GS_W   = GAIN_W + 1;
   localparam int P_W    = ERR_W + GS_W;
   localparam int I_W    = SUM_BITS + GS_W;
   localparam int D_W    = DELTA_W + GS_W;
   localparam int WIDE_W = SUM_BITS + 1;

   // state stage
   logic                      valid_a_ff, valid_a_in, ready_a;
   logic signed [ERR_W-1:0]   err_a_ff, err_a_in;
   logic signed [DELTA_W-1:0] delta_a_ff, delta_a_in;
   logic signed [ERR_W-1:0]   prev_ff, prev_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic signed [WIDE_W-1:0]  sum_wide;

   // product stage
   logic                      valid_b_ff, valid_b_in, ready_b;
   logic signed [ERR_W-1:0]   err_b_ff, err_b_in;
   logic signed [P_W-1:0]     p_b_ff, p_b_in;
   logic signed [I_W-1:0]     i_b_ff, i_b_in;
   logic signed [D_W-1:0]     d_b_ff, d_b_in;
   logic signed [GS_W-1:0]    gp_s, gi_s, gd_s;

   // sum stage
   logic                      valid_c_ff, valid_c_in, ready_c;
   logic signed [ERR_W-1:0]   err_c_ff, err_c_in;
   logic signed [ACC_W-1:0]   acc_c_ff, acc_c_in;

   assign ready_c  = !valid_c_ff || out_ready;
   assign ready_b  = !valid_b_ff || ready_c;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   // the sum register always belongs to the item held in the state stage
   always_comb begin
      valid_a_in = valid_a_ff;
      err_a_in   = err_a_ff;
      delta_a_in = delta_a_ff;
      prev_in    = prev_ff;
      sum_in     = sum_ff;
      sum_wide   = WIDE_W'(sum_ff) + WIDE_W'(in_error);
      if (ready_a) begin
         valid_a_in = in_valid;
         if (in_valid) begin
            err_a_in   = in_error;
            delta_a_in = DELTA_W'(in_error) - DELTA_W'(prev_ff);
            prev_in    = in_error;
            if (in_error == '0) begin
               sum_in = '0;
            end else if (sum_wide[WIDE_W-1] != sum_wide[WIDE_W-2]) begin
               // saturate on overflow of the sum
               sum_in = sum_wide[WIDE_W-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                           : {1'b0, {(SUM_BITS-1){1'b1}}};
            end else begin
               sum_in = sum_wide[SUM_BITS-1:0];
            end
         end
      end
   end

   assign gp_s = $signed({1'b0, gain_p});
   assign gi_s = $signed({1'b0, gain_i});
   assign gd_s = $signed({1'b0, gain_d});

   always_comb begin
      valid_b_in = valid_b_ff;
      err_b_in   = err_b_ff;
      p_b_in     = p_b_ff;
      i_b_in     = i_b_ff;
      d_b_in     = d_b_ff;
      if (ready_b) begin
         valid_b_in = valid_a_ff;
         err_b_in   = err_a_ff;
         p_b_in     = P_W'(err_a_ff) * P_W'(gp_s);
         i_b_in     = I_W'(sum_ff) * I_W'(gi_s);
         d_b_in     = D_W'(delta_a_ff) * D_W'(gd_s);
      end
   end

   always_comb begin
      valid_c_in = valid_c_ff;
      err_c_in   = err_c_ff;
      acc_c_in   = acc_c_ff;
      if (ready_c) begin
         valid_c_in = valid_b_ff;
         err_c_in   = err_b_ff;
         acc_c_in   = ACC_W'(p_b_ff) + ACC_W'(i_b_ff) + ACC_W'(d_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         prev_ff    <= '0;
         sum_ff     <= '0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
         prev_ff    <= prev_in;
         sum_ff     <= sum_in;
      end
      err_a_ff   <= err_a_in;
      delta_a_ff <= delta_a_in;
      err_b_ff   <= err_b_in;
      p_b_ff     <= p_b_in;
      i_b_ff     <= i_b_in;
      d_b_ff     <= d_b_in;
      err_c_ff   <= err_c_in;
      acc_c_ff   <= acc_c_in;
   end

   assign out_valid = valid_c_ff;
   assign out_acc   = acc_c_ff;
   assign out_error = err_c_ff;

endmodule

`default_nettype wire

[src/lfpd_drive.sv]
// lfpd_drive: scales the PID sum to a correction (truncated toward zero),
// applies it to the base speeds with clamping, zeroes both speeds on a lost
// line, and holds the result register. Uses lfpd_pkg.
`default_nettype none

module lfpd_drive
   import lfpd_pkg::*;
#(
   parameter int SUM_BITS = SUM_BITS_DEF
)(
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic signed [SUM_BITS+ACC_EXTRA-1:0] in_acc,
   input  wire logic signed [ERR_W-1:0]          in_error,
   input  wire logic signed [SPEED_W-1:0]        base_left,
   input  wire logic signed [SPEED_W-1:0]        base_right,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic signed [SPEED_W-1:0]             out_left,
   output logic signed [SPEED_W-1:0]             out_right,
   output logic signed [ERR_W-1:0]               out_error,
   output logic                                  out_halted
);

   localparam int ACC_W = SUM_BITS + ACC_EXTRA;
   localparam logic signed [ACC_W-1:0]   ROUND_ADJ = ACC_W'((1 << GAIN_FRAC) - 1);
   localparam logic signed [ACC_W-1:0]   CORR_HI   = ACC_W'(CORR_LIMIT);
   localparam logic signed [ACC_W-1:0]   CORR_LO   = -ACC_W'(CORR_LIMIT);
   localparam logic signed [DRIVE_W-1:0] SPEED_HI  = DRIVE_W'(SPEED_LIMIT);
   localparam logic signed [DRIVE_W-1:0] SPEED_LO  = -DRIVE_W'(SPEED_LIMIT);

   logic                       valid_d_ff, valid_d_in, ready_d;
   logic signed [ERR_W-1:0]    err_d_ff, err_d_in;
   logic signed [CORR_W-1:0]   corr_d_ff, corr_d_in;
   logic signed [ACC_W-1:0]    acc_adj, corr_full;

   logic                       valid_e_ff, valid_e_in, ready_e;
   logic signed [SPEED_W-1:0]  left_ff, left_in, right_ff, right_in;
   logic signed [ERR_W-1:0]    err_e_ff, err_e_in;
   logic                       halt_ff, halt_in, halt_now;
   logic signed [DRIVE_W-1:0]  left_raw, right_raw;

   assign ready_e  = !valid_e_ff || out_ready;
   assign ready_d  = !valid_d_ff || ready_e;
   assign in_ready = ready_d;

   // divide by 1024 toward zero; clip so the narrow speed adders suffice
   always_comb begin
      acc_adj    = in_acc + (in_acc[ACC_W-1] ? ROUND_ADJ : '0);
      corr_full  = acc_adj >>> GAIN_FRAC;
      valid_d_in = valid_d_ff;
      err_d_in   = err_d_ff;
      corr_d_in  = corr_d_ff;
      if (ready_d) begin
         valid_d_in = in_valid;
         err_d_in   = in_error;
         if (corr_full > CORR_HI) begin
            corr_d_in = CORR_W'(CORR_LIMIT);
         end else if (corr_full < CORR_LO) begin
            corr_d_in = -CORR_W'(CORR_LIMIT);
         end else begin
            corr_d_in = corr_full[CORR_W-1:0];
         end
      end
   end

   always_comb begin
      left_raw   = DRIVE_W'(base_left) + DRIVE_W'(corr_d_ff);
      right_raw  = DRIVE_W'(base_right) - DRIVE_W'(corr_d_ff);
      halt_now   = (err_d_ff == ERR_LOST_POS) || (err_d_ff == ERR_LOST_NEG);
      valid_e_in = valid_e_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      err_e_in   = err_e_ff;
      halt_in    = halt_ff;
      if (ready_e) begin
         valid_e_in = valid_d_ff;
         err_e_in   = err_d_ff;
         halt_in    = halt_now;
         if (halt_now) begin
            left_in  = '0;
            right_in = '0;
         end else begin
            if (left_raw >= SPEED_HI) begin
               left_in = SPEED_W'(SPEED_LIMIT);
            end else if (left_raw <= SPEED_LO) begin
               left_in = -SPEED_W'(SPEED_LIMIT);
            end else begin
               left_in = left_raw[SPEED_W-1:0];
            end
            if (right_raw >= SPEED_HI) begin
               right_in = SPEED_W'(SPEED_LIMIT);
            end else if (right_raw <= SPEED_LO) begin
               right_in = -SPEED_W'(SPEED_LIMIT);
            end else begin
               right_in = right_raw[SPEED_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else begin
         valid_d_ff <= valid_d_in;
         valid_e_ff <= valid_e_in;
      end
      err_d_ff  <= err_d_in;
      corr_d_ff <= corr_d_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      err_e_ff  <= err_e_in;
      halt_ff   <= halt_in;
   end

   assign out_valid  = valid_e_ff;
   assign out_left   = left_ff;
   assign out_right  = right_ff;
   assign out_error  = err_e_ff;
   assign out_halted = halt_ff;

endmodule

`default_nettype wire

[src/line_follow_pid_drive.sv]
// Line-following PID drive: one sensor scan per request, one speed pair out.
// Path: a request passes the request register, PID state, products, sum,
// correction and result register before its response is valid.
// Throughput: one request per cycle; each stage advances whenever the one
// after it is empty or moving, so stalls on rsp_tready back up stage by stage.
// Reset clears the pipeline, the PID state and the registers (threshold 3700).
`default_nettype none

module line_follow_pid_drive
   import lfpd_pkg::*;
#(
   parameter int SUM_BITS = SUM_BITS_DEF
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // sample_0 .. sample_11, 12 bits each, sample_0 lowest
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // left_speed [8:0], right_speed [17:9], line_error [26:18], zero above
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // halted
   output logic                        rsp_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam int ACC_W = SUM_BITS + ACC_EXTRA;

   cfg_type                  cfg_ff, cfg_in;
   logic [CSR_IDX_W-1:0]     csr_idx;
   logic                     csr_write;

   logic                     err_valid, err_ready;
   logic signed [ERR_W-1:0]  err_value;
   logic                     acc_valid, acc_ready;
   logic signed [ACC_W-1:0]  acc_value;
   logic signed [ERR_W-1:0]  acc_error;
   logic signed [SPEED_W-1:0] left_speed, right_speed;
   logic signed [ERR_W-1:0]  line_error;
   logic                     halted;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_BASE_LEFT:  cfg_in.base_left      = csr_pwdata[SPEED_W-1:0];
            REG_BASE_RIGHT: cfg_in.base_right     = csr_pwdata[SPEED_W-1:0];
            REG_GAIN_P:     cfg_in.gain_p         = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_I:     cfg_in.gain_i         = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_D:     cfg_in.gain_d         = csr_pwdata[GAIN_W-1:0];
            REG_THRESHOLD:  cfg_in.line_threshold = csr_pwdata[SAMPLE_W-1:0];
            REG_REAR_BANK:  cfg_in.rear_bank      = csr_pwdata[0];
            default:        cfg_in                = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_BASE_LEFT:  csr_prdata = CSR_DATA_W'(cfg_ff.base_left);
         REG_BASE_RIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.base_right);
         REG_GAIN_P:     csr_prdata = CSR_DATA_W'(cfg_ff.gain_p);
         REG_GAIN_I:     csr_prdata = CSR_DATA_W'(cfg_ff.gain_i);
         REG_GAIN_D:     csr_prdata = CSR_DATA_W'(cfg_ff.gain_d);
         REG_THRESHOLD:  csr_prdata = CSR_DATA_W'(cfg_ff.line_threshold);
         REG_REAR_BANK:  csr_prdata = CSR_DATA_W'(cfg_ff.rear_bank);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_left      <= '0;
         cfg_ff.base_right     <= '0;
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.line_threshold <= THRESHOLD_RESET;
         cfg_ff.rear_bank      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfpd_error u_error (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_samples     (req_tdata),
      .line_threshold (cfg_ff.line_threshold),
      .rear_bank      (cfg_ff.rear_bank),
      .out_valid      (err_valid),
      .out_ready      (err_ready),
      .out_error      (err_value)
   );

   lfpd_pid #(
      .SUM_BITS (SUM_BITS)
   ) u_pid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .in_error  (err_value),
      .gain_p    (cfg_ff.gain_p),
      .gain_i    (cfg_ff.gain_i),
      .gain_d    (cfg_ff.gain_d),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_acc   (acc_value),
      .out_error (acc_error)
   );

   lfpd_drive #(
      .SUM_BITS (SUM_BITS)
   ) u_drive (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (acc_valid),
      .in_ready   (acc_ready),
      .in_acc     (acc_value),
      .in_error   (acc_error),
      .base_left  (cfg_ff.base_left),
      .base_right (cfg_ff.base_right),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_left   (left_speed),
      .out_right  (right_speed),
      .out_error  (line_error),
      .out_halted (halted)
   );

   assign rsp_tdata = {{(RSP_DATA_W - SPEED_W - SPEED_W - ERR_W){1'b0}},
                       line_error, right_speed, left_speed};
   assign rsp_tuser = halted;

endmodule

`default_nettype wire

[src/lfpd_checker.sv]
// lfpd_checker: port-level checks on the response channel of the
// line-following PID drive, bound to the top level. Uses lfpd_pkg.
`default_nettype none

module lfpd_checker
   import lfpd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready
);

   // a held response keeps its payload until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped or changed while stalled");

   // reset leaves no stale response behind
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response valid just after reset");

   // a halt drives both motors to zero
   a_halt_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[2*SPEED_W-1:0] == '0)
      else $error("halted response with non-zero speed");

   // a halt only comes from a line error of plus or minus 100
   a_halt_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[2*SPEED_W +: ERR_W] == ERR_LOST_POS) ||
         (rsp_tdata[2*SPEED_W +: ERR_W] == ERR_LOST_NEG))
      else $error("halted response without a lost-line error");

   // clamping never lets a speed reach -256
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[SPEED_W-1:0] != {1'b1, {(SPEED_W-1){1'b0}}}) &&
         (rsp_tdata[SPEED_W +: SPEED_W] != {1'b1, {(SPEED_W-1){1'b0}}}))
      else $error("speed outside the clamp range");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
